// ===== hw/rtl/rmd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared codes and controller/datapath interface types for the repeated
// marker deframer.
// ----------------------------------------------------------------------------
package rmd_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_MARKER  = 2'd0;
  localparam logic [1:0] CFG_END_MARKER    = 2'd1;
  localparam logic [1:0] CFG_MARKER_REPEAT = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_PAYLOAD  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic step;       // input byte transferred this cycle
    logic load_stat;  // load the pending status result into the output register
    logic load_byte;  // load the next buffered payload byte into the output register
  } rmd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ev_status;  // this byte ends a frame with a single status result
    logic ev_payload; // this byte ends a frame with buffered payload
    logic out_free;   // output register can take a result this cycle
    logic rd_last;    // pointer sits on the final payload byte
  } rmd_stat_t;

endpackage

// ===== hw/rtl/rmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmd_ctrl
// Sequencer: takes input bytes, then drains a status result or payload burst.
// ----------------------------------------------------------------------------
module rmd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rmd_pkg::rmd_stat_t stat,
  output rmd_pkg::rmd_cmd_t  cmd
);
  import rmd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_STAT = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.step      = 1'b0;
    cmd.load_stat = 1'b0;
    cmd.load_byte = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.step = in_valid;
        if (in_valid && stat.ev_status) begin
          state_next = S_STAT;
        end else if (in_valid && stat.ev_payload) begin
          state_next = S_READ;
        end
      end
      S_STAT: begin
        cmd.load_stat = stat.out_free;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        cmd.load_byte = stat.out_free;
        if (stat.out_free && stat.rd_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rmd_dp.sv =====
// ----------------------------------------------------------------------------
// rmd_dp
// Datapath: configuration registers, marker run tracking, frame buffer and
// output register.
// ----------------------------------------------------------------------------
module rmd_dp #(
  parameter int BUFFER_DEPTH = 32,
  parameter int MAX_REPEAT   = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [7:0]         rx_byte,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         payload_byte,
  output logic [1:0]         frame_status,
  output logic               last_of_frame,
  input  rmd_pkg::rmd_cmd_t  cmd,
  output rmd_pkg::rmd_stat_t stat
);
  import rmd_pkg::*;

  localparam int RUN_W = $clog2(MAX_REPEAT + 1);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam int LEN_W = (CNT_W > RUN_W) ? CNT_W : RUN_W;

  // Configuration
  logic [7:0] start_marker;
  logic [7:0] end_marker;
  logic [3:0] marker_repeat;

  // Framing state
  logic             in_frame;
  logic [RUN_W-1:0] marker_run;
  logic [CNT_W-1:0] byte_count;

  // Readout
  logic [7:0]       frame_buffer [BUFFER_DEPTH];
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] rd_ptr;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] len_m1;
  logic [1:0]       stat_code;

  // Step evaluation
  logic [3:0]       rep_raw;
  logic [RUN_W-1:0] rep;
  logic [RUN_W-1:0] run_inc;
  logic [CNT_W-1:0] cnt_inc;
  logic [LEN_W-1:0] cnt_ext;
  logic [LEN_W-1:0] rep_ext;
  logic [LEN_W-1:0] frame_len;
  logic             overflow;
  logic             frame_end;
  logic             buf_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker  <= 8'd0;
      end_marker    <= 8'hFF;
      marker_repeat <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_MARKER:  start_marker  <= cfg_data;
        CFG_END_MARKER:    end_marker    <= cfg_data;
        CFG_MARKER_REPEAT: marker_repeat <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rep_raw = marker_repeat;
    if (rep_raw == 4'd0) begin
      rep_raw = 4'd1;
    end
    if (rep_raw > 4'(MAX_REPEAT)) begin
      rep_raw = 4'(MAX_REPEAT);
    end
    rep       = RUN_W'(rep_raw);
    run_inc   = marker_run + RUN_W'(1);
    cnt_inc   = byte_count + CNT_W'(1);
    cnt_ext   = LEN_W'(cnt_inc);
    rep_ext   = LEN_W'(rep);
    frame_len = (cnt_ext >= rep_ext) ? (cnt_ext - rep_ext) : '0;
    overflow  = in_frame && (byte_count >= CNT_W'(BUFFER_DEPTH));
    buf_wr    = cmd.step && in_frame && !overflow;
    frame_end = in_frame && !overflow && (rx_byte == end_marker) && (run_inc >= rep);
  end

  assign stat.ev_status  = overflow || (frame_end && (frame_len == '0));
  assign stat.ev_payload = frame_end && (frame_len != '0);
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.rd_last    = (rd_ptr == len_m1);

  // Hunt for markers, count frame bytes and marker runs
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      marker_run <= '0;
      byte_count <= '0;
    end else if (cmd.step) begin
      if (!in_frame) begin
        if (rx_byte == start_marker) begin
          if (run_inc >= rep) begin
            in_frame   <= 1'b1;
            marker_run <= '0;
            byte_count <= '0;
          end else begin
            marker_run <= run_inc;
          end
        end else begin
          marker_run <= '0;
        end
      end else if (overflow || frame_end) begin
        in_frame   <= 1'b0;
        marker_run <= '0;
        byte_count <= '0;
      end else begin
        byte_count <= cnt_inc;
        marker_run <= (rx_byte == end_marker) ? run_inc : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      stat_code <= overflow ? STATUS_OVERFLOW : STATUS_EMPTY;
      len_m1    <= IDX_W'(frame_len - LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (buf_wr) begin
      frame_buffer[byte_count[IDX_W-1:0]] <= rx_byte;
    end
  end

  // Read address runs one ahead so rd_data always holds the byte at rd_ptr
  always_comb begin
    if (cmd.step) begin
      rd_addr = '0;
    end else if (cmd.load_byte) begin
      rd_addr = rd_ptr + IDX_W'(1);
    end else begin
      rd_addr = rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= frame_buffer[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
    end else begin
      rd_ptr <= rd_addr;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_stat || cmd.load_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_stat) begin
      payload_byte  <= 8'd0;
      frame_status  <= stat_code;
      last_of_frame <= 1'b1;
    end else if (cmd.load_byte) begin
      payload_byte  <= rd_data;
      frame_status  <= STATUS_PAYLOAD;
      last_of_frame <= stat.rd_last;
    end
  end

endmodule

// ===== hw/rtl/repeated_marker_deframer_core.sv =====
// ----------------------------------------------------------------------------
// repeated_marker_deframer_core
// Byte deframer that opens a frame on a repeated start marker, buffers the
// frame, and releases its payload when a repeated end marker closes it.
// ----------------------------------------------------------------------------
// Rate: a byte that does not close a frame does not hold the input, so bytes
// are transferred back to back while a frame is being collected. A byte that
// completes an empty frame, or arrives with the buffer full, holds the input
// while its status result goes to the output register, longer if the sink
// stalls. A byte that completes a frame with payload bytes holds the input
// until all of them have gone out: the frame buffer has a single read
// port and the burst leaves it one byte per cycle, fewer if the sink stalls.
// The buffer holds BUFFER_DEPTH bytes including the trailing end markers; a
// byte arriving when it is full aborts the frame with an overflow status. The
// buffer needs no clearing pass: only bytes written in the current frame are
// ever read. Configuration writes are taken in any cycle but must only be
// issued while the block is idle.
module repeated_marker_deframer_core #(
  parameter int BUFFER_DEPTH = 32,
  parameter int MAX_REPEAT   = 8
) (
  input  logic       clk,
  input  logic       rst,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // received bytes
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  // frame results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic [1:0] frame_status,
  output logic       last_of_frame
);
  import rmd_pkg::*;

  rmd_cmd_t  cmd;
  rmd_stat_t stat;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  // Sequencer: accept, then drain status or payload
  rmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Marker tracking, frame buffer and output register
  rmd_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_REPEAT   (MAX_REPEAT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (rx_byte),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .payload_byte  (payload_byte),
    .frame_status  (frame_status),
    .last_of_frame (last_of_frame),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

// ===== sim/repeated_marker_deframer_core_test.sv =====
// ----------------------------------------------------------------------------
// repeated_marker_deframer_core_test
// Self-checking bench for the repeated marker deframer. Drives received bytes
// through valid/ready with random gaps and sink stalls, predicts every frame
// result from a shadow copy of the deframer state and registers, and compares
// each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module repeated_marker_deframer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rmd_pkg::*;

  localparam int BUFFER_DEPTH = 32;
  localparam int MAX_REPEAT   = 8;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  // Cycles to let pass once nothing is expected: covers bytes that give no result
  localparam int DRAIN_CYCLES = 40;
  // Index with no register behind it; writes to it must change nothing
  localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } frame_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_START_MARKER;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] payload_byte;
  logic [1:0] frame_status;
  logic       last_of_frame;

  repeated_marker_deframer_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .MAX_REPEAT  (MAX_REPEAT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .frame_status (frame_status),
    .last_of_frame(last_of_frame)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bytes waiting to be offered, and frame results still owed by the block
  logic [7:0]    rx_backlog[$];
  frame_result_t frame_results_due[$];
  int unsigned   bytes_queued = 0;
  int unsigned   error_count = 0;

  // Idle rates in percent, changed per test phase
  int unsigned sender_idle_pct = 11;
  int unsigned receiver_idle_pct = 51;

  // Shadow registers, tracking every accepted configuration write
  logic [7:0] reg_start_marker = 8'h00;
  logic [7:0] reg_end_marker = 8'hFF;
  logic [3:0] reg_marker_repeat = 4'd1;

  // Shadow deframer state
  logic        pred_framing = 1'b0;
  int unsigned pred_run = 0;
  int unsigned pred_count = 0;
  logic [7:0]  pred_buffer[BUFFER_DEPTH];

  // Signature length actually in force: zero acts as one, clamp at the maximum
  function automatic int unsigned signature_len();
    if (reg_marker_repeat == 4'd0) return 1;
    if (reg_marker_repeat > 4'(MAX_REPEAT)) return MAX_REPEAT;
    return 32'(reg_marker_repeat);
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [7:0] value);
    case (idx)
      CFG_START_MARKER:  reg_start_marker = value;
      CFG_END_MARKER:    reg_end_marker = value;
      CFG_MARKER_REPEAT: reg_marker_repeat = value[3:0];
      default: ;
    endcase
  endfunction

  // Advance the shadow deframer by one received byte; queue whatever it owes
  function automatic void deframe_byte(input logic [7:0] rx);
    int unsigned   rep;
    int unsigned   len;
    frame_result_t res;
    rep = signature_len();
    if (!pred_framing) begin
      // Hunting: only the start marker counts
      if (rx == reg_start_marker) begin
        pred_run++;
        if (pred_run >= rep) begin
          pred_framing = 1'b1;
          pred_run = 0;
          pred_count = 0;
        end
      end else begin
        pred_run = 0;
      end
      return;
    end
    // Full buffer: any byte, end marker included, aborts the frame
    if (pred_count >= BUFFER_DEPTH) begin
      pred_framing = 1'b0;
      pred_run = 0;
      pred_count = 0;
      res = '{data: 8'h00, status: STATUS_OVERFLOW, last: 1'b1};
      frame_results_due.push_back(res);
      return;
    end
    pred_buffer[pred_count[PTR_W-1:0]] = rx;
    pred_count++;
    if (rx != reg_end_marker) begin
      pred_run = 0;
      return;
    end
    pred_run++;
    if (pred_run < rep) return;
    // End signature complete: drop the trailing markers, release the rest
    len = (pred_count >= rep) ? pred_count - rep : 0;
    if (len == 0) begin
      res = '{data: 8'h00, status: STATUS_EMPTY, last: 1'b1};
      frame_results_due.push_back(res);
    end else begin
      for (int unsigned i = 0; i < len; i++) begin
        res = '{data: pred_buffer[i[PTR_W-1:0]], status: STATUS_PAYLOAD,
                last: (i + 1 == len)};
        frame_results_due.push_back(res);
      end
    end
    pred_framing = 1'b0;
    pred_run = 0;
    pred_count = 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $realtime, msg);
    error_count++;
  endtask

  // Driver: offer the next byte when the slot is free, hold it until transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) deframe_byte(rx_byte);
      if (!in_valid || in_ready) begin
        if (rx_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction, then
  // decide whether to stall the sink on the next cycle
  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h/%0d/%0b",
                                    payload_byte, frame_status, last_of_frame));
        end else begin
          want = frame_results_due.pop_front();
          if (payload_byte !== want.data)
            report_mismatch($sformatf("payload_byte %h, want %h", payload_byte, want.data));
          if (frame_status !== want.status)
            report_mismatch($sformatf("frame_status %0d, want %0d", frame_status, want.status));
          if (last_of_frame !== want.last)
            report_mismatch($sformatf("last_of_frame %0b, want %0b", last_of_frame, want.last));
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    bytes_queued++;
  endtask

  // Issue one register write and wait for its transfer
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every byte is taken and every owed result has arrived
  task automatic wait_idle();
    while (rx_backlog.size() != 0 || in_valid || frame_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Hunting noise: bytes that never match the start marker
  task automatic queue_noise(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(255));
      if (b == reg_start_marker) b = ~b;
      queue_byte(b);
    end
  endtask

  // A well-formed frame: start signature (sometimes after a broken one),
  // random payload with short end marker runs, then the end signature
  task automatic queue_frame(input int unsigned payload_len);
    int unsigned rep;
    int unsigned run;
    int unsigned i;
    logic [7:0]  b;
    rep = signature_len();
    if (rep > 1 && $urandom_range(3) == 0) begin
      repeat ($urandom_range(1, rep - 1)) queue_byte(reg_start_marker);
      queue_byte(reg_start_marker ^ 8'h01);
    end
    repeat (rep) queue_byte(reg_start_marker);
    run = 0;
    for (i = 0; i < payload_len; i++) begin
      b = ($urandom_range(4) == 0) ? reg_end_marker : 8'($urandom_range(255));
      // never close early, and never run straight into the trailer
      if (b == reg_end_marker && (run + 1 >= rep || i + 1 == payload_len)) b = ~b;
      run = (b == reg_end_marker) ? run + 1 : 0;
      queue_byte(b);
    end
    repeat (rep) queue_byte(reg_end_marker);
  endtask

  initial begin
    logic [7:0]  seq[$];
    logic [3:0]  rep_choice[6];
    logic [7:0]  start_val;
    logic [7:0]  end_val;
    int unsigned len;
    int unsigned phase_base;

    rep_choice = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd0, 4'd0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset settings (start 00, end FF, single marker): an empty
    // frame, noise, then a frame carrying the byte extremes and a start marker
    seq = '{8'h00, 8'hFF, 8'h12, 8'h00, 8'h00, 8'h80, 8'h7F, 8'hFE, 8'h01, 8'hFF};
    foreach (seq[k]) queue_byte(seq[k]);
    wait_idle();

    // Directed, equal markers with a two-byte signature: broken start run,
    // frame with a broken end run inside, then an empty frame
    write_reg(CFG_START_MARKER, 8'hA5);
    write_reg(CFG_END_MARKER, 8'hA5);
    write_reg(CFG_MARKER_REPEAT, 8'h02);
    write_reg(CFG_UNUSED_INDEX, 8'h5A);
    seq = '{8'hA5, 8'h3C, 8'hA5, 8'hA5, 8'hA5, 8'h5A, 8'hA5, 8'hA5,
            8'hA5, 8'hA5, 8'hA5, 8'hA5};
    foreach (seq[k]) queue_byte(seq[k]);
    wait_idle();

    // Random phases: new settings each time, idle profiles in three pairs
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        sender_idle_pct = 11;
        receiver_idle_pct = 51;
      end else if (ph < 4) begin
        sender_idle_pct = 51;
        receiver_idle_pct = 11;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      start_val = 8'($urandom_range(255));
      end_val = ($urandom_range(3) == 0) ? start_val : 8'($urandom_range(255));
      if (ph == 1) begin
        start_val = 8'hFF;
        end_val = 8'h00;
      end
      if (ph >= 4) rep_choice[ph[2:0]] = 4'($urandom_range(15));
      write_reg(CFG_START_MARKER, start_val);
      write_reg(CFG_END_MARKER, end_val);
      // upper nibble is junk the register must ignore
      write_reg(CFG_MARKER_REPEAT, {4'($urandom_range(15)), rep_choice[ph[2:0]]});
      if (ph == 0) write_reg(CFG_UNUSED_INDEX, 8'($urandom_range(255)));

      phase_base = bytes_queued;
      // Buffer extremes: exactly full, overflow on an end marker, overflow
      // on a payload byte
      case (ph)
        0: queue_frame(BUFFER_DEPTH - signature_len());
        1: queue_frame(BUFFER_DEPTH + 1 - signature_len());
        2: queue_frame(BUFFER_DEPTH + 8);
        default: ;
      endcase
      while (bytes_queued - phase_base < 8) begin
        if ($urandom_range(3) == 0) queue_noise($urandom_range(1, 4));
        len = ($urandom_range(7) == 0) ? $urandom_range(24, 34) : $urandom_range(0, 6);
        queue_frame(len);
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("repeated_marker_deframer_core_test passed");
    end else begin
      $display("repeated_marker_deframer_core_test failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("repeated_marker_deframer_core_test failed");
    $finish;
  end

endmodule
